// ===== hdl/lkvc_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
// No dependencies; imported by lkvc_rank, the cache top and the testbench.
package lkvc_pkg;

  localparam int unsigned DefEntries = 16;
  localparam int unsigned CapW       = 5;
  localparam int unsigned KeyW       = 32;
  localparam int unsigned ValW       = 32;

  localparam logic ActGet = 1'b0;
  localparam logic ActPut = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

  typedef enum logic [1:0] {
    RK_NONE,
    RK_TOUCH,
    RK_INSERT,
    RK_EVICT_INSERT
  } rank_op_e;

  // Command from the sequencer to the valid/recency array.
  typedef struct packed {
    rank_op_e op;
  } rank_cmd_t;

endpackage

// ===== hdl/lkvc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Self-contained; used for the key and value stores.
module lkvc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/lkvc_rank.sv =====
// Valid bits, recency ranks and fill count of the cache entries.
// Depends on lkvc_pkg for the rank command type.
module lkvc_rank #(
  parameter int unsigned Entries = lkvc_pkg::DefEntries,
  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1,
  localparam int unsigned CntW = $clog2(Entries + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lkvc_pkg::rank_cmd_t cmd_i,
  input  logic [IdxW-1:0]     sel_idx_i,   // touch target or eviction victim
  input  logic [IdxW-1:0]     slot_idx_i,  // insert position
  input  logic [IdxW-1:0]     look_idx_i,
  output logic                look_valid_o,
  output logic [IdxW-1:0]     look_rank_o,
  output logic [Entries-1:0]  valid_o,
  output logic [CntW-1:0]     count_o
);
  import lkvc_pkg::*;

  logic [Entries-1:0] valid_q, valid_d;
  logic [IdxW-1:0]    rank_q [Entries];
  logic [IdxW-1:0]    rank_d [Entries];
  logic [CntW-1:0]    count_q, count_d;
  logic [IdxW-1:0]    sel_rank;

  assign sel_rank     = rank_q[sel_idx_i];
  assign look_valid_o = valid_q[look_idx_i];
  assign look_rank_o  = rank_q[look_idx_i];
  assign valid_o      = valid_q;
  assign count_o      = count_q;

  always_comb begin
    valid_d  = valid_q;
    rank_d   = rank_q;
    count_d  = count_q;
    unique case (cmd_i.op)
      RK_TOUCH: begin
        // age every entry younger than the touched one
        for (int i = 0; i < Entries; i++) begin
          if (valid_q[i] && (rank_q[i] < sel_rank)) begin
            rank_d[i] = rank_q[i] + IdxW'(1);
          end
        end
        rank_d[sel_idx_i] = '0;
      end
      RK_INSERT: begin
        for (int i = 0; i < Entries; i++) begin
          if (valid_q[i]) begin
            rank_d[i] = rank_q[i] + IdxW'(1);
          end
        end
        valid_d[slot_idx_i] = 1'b1;
        rank_d[slot_idx_i]  = '0;
        count_d             = count_q + CntW'(1);
      end
      RK_EVICT_INSERT: begin
        // victim leaves, new entry comes in: count unchanged
        for (int i = 0; i < Entries; i++) begin
          if (valid_q[i] && (IdxW'(i) != sel_idx_i)) begin
            rank_d[i] = rank_q[i] + IdxW'(1);
          end
        end
        valid_d[sel_idx_i]  = 1'b0;
        rank_d[sel_idx_i]   = '0;
        valid_d[slot_idx_i] = 1'b1;
        rank_d[slot_idx_i]  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < Entries; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
      rank_q  <= rank_d;
    end
  end

endmodule

// ===== hdl/lru_key_value_cache.sv =====
// Fully associative key-value cache with least-recently-used replacement.
// The scan steps through every entry, the registered RAM read running ahead of the compare,
// followed by an update step. A new item is taken only once the block is back in idle;
// the update step also waits while the output register holds a result not yet taken.
// Reset clears valid bits, ranks, count and sets capacity to Entries; key and
// value RAMs are not cleared, so no clearing pass is needed.
module lru_key_value_cache #(
  parameter int unsigned Entries = lkvc_pkg::DefEntries,
  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1,
  localparam int unsigned CntW = $clog2(Entries + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lkvc_pkg::CapW-1:0] cfg_wdata_i,    // capacity
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [63:0]               s_axis_tdata,   // [31:0] key, [63:32] value
  input  logic [0:0]                s_axis_tuser,   // [0] action
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [31:0]               m_axis_tdata,   // [31:0] read_value
  output logic [0:0]                m_axis_tuser    // [0] hit
);
  import lkvc_pkg::*;

  localparam int unsigned CmpW = (CntW > CapW) ? CntW : CapW;

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] cnt_m1;

  logic            act_q;
  logic [KeyW-1:0] key_q;
  logic [ValW-1:0] val_in_q;

  logic [CntW-1:0] eff_cap_q, eff_cap_wr;
  logic [CmpW-1:0] cfg_ext;

  // compare unit results
  logic            hit_q, free_found_q;
  logic [IdxW-1:0] hit_idx_q, free_idx_q, victim_idx_q;
  logic [ValW-1:0] hit_val_q;

  logic            out_valid_q, out_hit_q;
  logic [ValW-1:0] out_data_q;

  logic            accept, out_free, cmp_act, do_update, full;
  logic [IdxW-1:0] cmp_idx, scan_addr, slot_idx, sel_idx;
  logic [KeyW-1:0] key_rdata;
  logic [ValW-1:0] val_rdata;
  logic            look_valid;
  logic [IdxW-1:0] look_rank;
  logic [Entries-1:0] valid_vec;
  logic [CntW-1:0] count, count_m1;
  rank_cmd_t       rank_cmd;
  logic            key_we, val_we;
  logic [IdxW-1:0] val_waddr;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign cnt_m1        = cnt_q - CntW'(1);
  assign cmp_idx       = cnt_m1[IdxW-1:0];
  assign cmp_act       = (state_q == ST_SCAN) && (cnt_q != '0);
  assign scan_addr     = (cnt_q < CntW'(Entries)) ? cnt_q[IdxW-1:0] : '0;
  assign count_m1      = count - CntW'(1);
  assign full          = (count >= eff_cap_q);
  assign do_update     = (state_q == ST_UPDATE) && out_free;

  // capacity 0 acts as 1, anything above Entries acts as Entries
  always_comb begin
    cfg_ext = CmpW'(cfg_wdata_i);
    if (cfg_wdata_i == '0) begin
      eff_cap_wr = CntW'(1);
    end else if (cfg_ext > CmpW'(Entries)) begin
      eff_cap_wr = CntW'(Entries);
    end else begin
      eff_cap_wr = CntW'(cfg_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_cap_q <= CntW'(Entries);
    end else if (cfg_we_i) begin
      eff_cap_q <= eff_cap_wr;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SCAN;
          cnt_d   = '0;
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(Entries)) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q    <= s_axis_tuser[0];
      key_q    <= s_axis_tdata[KeyW-1:0];
      val_in_q <= s_axis_tdata[KeyW+ValW-1:KeyW];
    end
  end

  // shared key comparator, one entry per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
    end else if (accept) begin
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
    end else if (cmp_act) begin
      if (look_valid && (key_rdata == key_q) && !hit_q) begin
        hit_q <= 1'b1;
      end
      if (!look_valid && !free_found_q) begin
        free_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmp_act) begin
      if (look_valid && (key_rdata == key_q) && !hit_q) begin
        hit_idx_q <= cmp_idx;
        hit_val_q <= val_rdata;
      end
      if (!look_valid && !free_found_q) begin
        free_idx_q <= cmp_idx;
      end
      // least recent entry holds rank count-1
      if (look_valid && (CntW'(look_rank) == count_m1)) begin
        victim_idx_q <= cmp_idx;
      end
    end
  end

  // update decision
  always_comb begin
    rank_cmd.op = RK_NONE;
    sel_idx     = hit_idx_q;
    slot_idx    = free_idx_q;
    key_we      = 1'b0;
    val_we      = 1'b0;
    val_waddr   = free_idx_q;
    if (do_update) begin
      priority if (hit_q) begin
        rank_cmd.op = RK_TOUCH;
        val_we      = (act_q == ActPut);
        val_waddr   = hit_idx_q;
      end else if (act_q == ActPut && full) begin
        rank_cmd.op = RK_EVICT_INSERT;
        sel_idx     = victim_idx_q;
        slot_idx    = (free_found_q && (free_idx_q < victim_idx_q)) ? free_idx_q
                                                                    : victim_idx_q;
        key_we      = 1'b1;
        val_we      = 1'b1;
        val_waddr   = slot_idx;
      end else if (act_q == ActPut && free_found_q) begin
        rank_cmd.op = RK_INSERT;
        key_we      = 1'b1;
        val_we      = 1'b1;
      end else begin
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_update) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_update) begin
      out_hit_q  <= hit_q;
      out_data_q <= (hit_q && (act_q == ActGet)) ? hit_val_q : '0;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_hit_q;

  lkvc_ram #(
    .Width (KeyW),
    .Depth (Entries)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (slot_idx),
    .wdata_i (key_q),
    .raddr_i (scan_addr),
    .rdata_o (key_rdata)
  );

  lkvc_ram #(
    .Width (ValW),
    .Depth (Entries)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_in_q),
    .raddr_i (scan_addr),
    .rdata_o (val_rdata)
  );

  lkvc_rank #(
    .Entries (Entries)
  ) u_rank (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (rank_cmd),
    .sel_idx_i    (sel_idx),
    .slot_idx_i   (slot_idx),
    .look_idx_i   (cmp_idx),
    .look_valid_o (look_valid),
    .look_rank_o  (look_rank),
    .valid_o      (valid_vec),
    .count_o      (count)
  );

  // fill count tracks the number of valid entries
  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == int'(count))
    else $error("entry count differs from valid bits");

  // a hit never changes the fill count
  a_hit_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_update && hit_q) |=> $stable(count))
    else $error("count changed on a hit");

  // the update step always leaves a result presented and the sequencer idle
  a_result_after_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_update |=> (m_axis_tvalid && (state_q == ST_IDLE)))
    else $error("result not presented after update");

  // no input is taken while the scan is running
  a_no_accept_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !s_axis_tready)
    else $error("ready raised during scan");

endmodule

// ===== dv/lru_key_value_cache_tb.sv =====
// Self-checking testbench for lru_key_value_cache: a directed table, then random
// get/put traffic, checked against table answers or a behavioral LRU shadow.
// Depends on lkvc_pkg and the lru_key_value_cache RTL.
module lru_key_value_cache_tb;
  import lkvc_pkg::*;

  localparam int          Ways          = DefEntries;
  localparam int unsigned ClkPeriod     = 20;
  localparam int unsigned SettleCycles  = 3;
  localparam int unsigned TailCycles    = DefEntries + 8;
  localparam int unsigned TimeoutCycles = 600_000;
  localparam int unsigned NumSegs       = 8;
  localparam int unsigned SegItems      = 230;
  localparam int unsigned PoolMax       = 24;
  localparam int unsigned MaxReports    = 10;
  localparam int unsigned NumDir        = 20;

  typedef struct packed {
    logic            hit;
    logic [ValW-1:0] read_value;
  } cache_resp_t;

  // One directed item; typed = 1 means resp holds the known answer.
  typedef struct packed {
    logic            set_cap;
    logic [CapW-1:0] cap;
    logic            act;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
    logic            typed;
    cache_resp_t     resp;
  } dir_row_t;

  logic            clk_i;
  logic            rst_ni        = 1'b0;
  logic            cfg_we_i      = 1'b0;
  logic [CapW-1:0] cfg_wdata_i   = '0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [63:0]     s_axis_tdata  = '0;
  logic [0:0]      s_axis_tuser  = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [31:0]     m_axis_tdata;
  logic [0:0]      m_axis_tuser;

  // Shadow copy of the cache contents and the capacity register.
  logic            line_valid [Ways];
  logic [KeyW-1:0] line_key   [Ways];
  logic [ValW-1:0] line_val   [Ways];
  int unsigned     line_rank  [Ways];
  int unsigned     line_count;
  logic [CapW-1:0] cap_reg;

  cache_resp_t expected_resp [$];
  int unsigned src_idle_pct  = 13;
  int unsigned sink_idle_pct = 62;
  int unsigned mismatches    = 0;
  int unsigned checked       = 0;
  int unsigned hits_seen     = 0;
  int unsigned items_sent    = 0;
  int unsigned cap_writes    = 0;

  dir_row_t dir_rows [NumDir] = '{
    '{1'b0, 5'd0,  ActGet, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000}},
    '{1'b0, 5'd0,  ActPut, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '{1'b0, 32'h0000_0000}},
    '{1'b0, 5'd0,  ActGet, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, '{1'b1, 32'h8000_0000}},
    '{1'b0, 5'd0,  ActPut, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, '{1'b0, 32'h0000_0000}},
    '{1'b0, 5'd0,  ActGet, 32'h8000_0000, 32'h0000_0000, 1'b1, '{1'b1, 32'h7FFF_FFFF}},
    '{1'b0, 5'd0,  ActPut, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0000_0000}},
    '{1'b0, 5'd0,  ActPut, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{1'b1, 32'h0000_0000}},
    '{1'b0, 5'd0,  ActGet, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0000_0000}},
    '{1'b0, 5'd0,  ActGet, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0000_0000}},
    // capacity 0 acts as 1 and sits below the count: only one eviction
    '{1'b1, 5'd0,  ActPut, 32'h0000_0001, 32'h0000_0011, 1'b1, '{1'b0, 32'h0000_0000}},
    '{1'b0, 5'd0,  ActGet, 32'h8000_0000, 32'h0000_0000, 1'b0, '0},
    '{1'b0, 5'd0,  ActGet, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, '0},
    '{1'b0, 5'd0,  ActPut, 32'h0000_0002, 32'h0000_0022, 1'b0, '0},
    '{1'b1, 5'd31, ActPut, 32'h0000_0003, 32'h0000_0033, 1'b0, '0},
    '{1'b1, 5'd1,  ActPut, 32'h0000_0004, 32'h0000_0044, 1'b0, '0},
    '{1'b0, 5'd0,  ActGet, 32'h0000_0003, 32'h0000_0000, 1'b0, '0},
    '{1'b0, 5'd0,  ActPut, 32'h0000_0005, 32'h0000_0055, 1'b0, '0},
    '{1'b0, 5'd0,  ActGet, 32'h0000_0004, 32'h0000_0000, 1'b0, '0},
    '{1'b1, 5'd16, ActGet, 32'h0000_0005, 32'h0000_0000, 1'b0, '0},
    '{1'b1, 5'd17, ActPut, 32'h0000_0006, 32'h0000_0066, 1'b0, '0}
  };

  lru_key_value_cache dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Applies one get/put to the shadow cache and returns what the block must answer.
  function automatic cache_resp_t cache_access(input logic act, input logic [KeyW-1:0] k,
                                               input logic [ValW-1:0] v);
    int          hit_idx;
    int          victim;
    int          slot;
    int unsigned limit;
    int unsigned age;
    int unsigned best;
    cache_resp_t r;
    hit_idx = -1;
    for (int i = 0; i < Ways; i++) begin
      if (hit_idx < 0 && line_valid[i] && line_key[i] == k) hit_idx = i;
    end
    r.hit        = (hit_idx >= 0);
    r.read_value = '0;
    if (hit_idx >= 0) begin
      if (act == ActGet) r.read_value = line_val[hit_idx];
      else line_val[hit_idx] = v;
      age = line_rank[hit_idx];
      for (int i = 0; i < Ways; i++) begin
        if (line_valid[i] && line_rank[i] < age) line_rank[i]++;
      end
      line_rank[hit_idx] = 0;
    end else if (act == ActPut) begin
      limit = (cap_reg == '0) ? 1 : (cap_reg > Ways) ? Ways : cap_reg;
      if (line_count >= limit) begin
        victim = -1;
        best   = 0;
        for (int i = 0; i < Ways; i++) begin
          if (line_valid[i] && (victim < 0 || line_rank[i] > best)) begin
            victim = i;
            best   = line_rank[i];
          end
        end
        if (victim >= 0) begin
          line_valid[victim] = 1'b0;
          line_rank[victim]  = 0;
          if (line_count > 0) line_count--;
        end
      end
      slot = -1;
      for (int i = 0; i < Ways; i++) begin
        if (slot < 0 && !line_valid[i]) slot = i;
      end
      if (slot >= 0) begin
        for (int i = 0; i < Ways; i++) begin
          if (line_valid[i]) line_rank[i]++;
        end
        line_valid[slot] = 1'b1;
        line_key[slot]   = k;
        line_val[slot]   = v;
        line_rank[slot]  = 0;
        line_count++;
      end
    end
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MaxReports) $display("MISMATCH: %s", msg);
  endtask

  // Returns at a rising edge once every expected result has been taken.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_resp.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [CapW-1:0] cap);
    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cap_reg = cap;
    cap_writes++;
  endtask

  task automatic send_item(input logic act, input logic [KeyW-1:0] k,
                           input logic [ValW-1:0] v, input logic use_typed,
                           input cache_resp_t typed_resp);
    cache_resp_t predicted;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {v, k};
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = cache_access(act, k, v);
    expected_resp.push_back(use_typed ? typed_resp : predicted);
    items_sent++;
  endtask

  // Result sink: random backpressure and in-order comparison.
  always @(posedge clk_i) begin : result_check
    cache_resp_t want;
    if (rst_ni) m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (m_axis_tuser[0]) hits_seen++;
      if (expected_resp.size() == 0) begin
        note_mismatch($sformatf("result with nothing expected: hit %0b value %h",
                                m_axis_tuser[0], m_axis_tdata));
      end else begin
        want = expected_resp.pop_front();
        checked++;
        if (m_axis_tuser[0] !== want.hit)
          note_mismatch($sformatf("result %0d hit: expected %0b, got %0b",
                                  checked, want.hit, m_axis_tuser[0]));
        if (m_axis_tdata !== want.read_value)
          note_mismatch($sformatf("result %0d read_value: expected %h, got %h",
                                  checked, want.read_value, m_axis_tdata));
      end
    end
  end

  initial begin : stimulus
    logic [KeyW-1:0] key_pool [PoolMax];
    int unsigned     pool_n;
    logic [KeyW-1:0] k;
    logic            act;
    logic [CapW-1:0] cap;
    for (int i = 0; i < Ways; i++) begin
      line_valid[i] = 1'b0;
      line_key[i]   = '0;
      line_val[i]   = '0;
      line_rank[i]  = 0;
    end
    line_count = 0;
    cap_reg    = CapW'(Ways);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].set_cap) set_capacity(dir_rows[r].cap);
      send_item(dir_rows[r].act, dir_rows[r].key, dir_rows[r].value,
                dir_rows[r].typed, dir_rows[r].resp);
    end

    for (int seg = 0; seg < NumSegs; seg++) begin
      unique case (seg)
        0:       cap = CapW'(Ways);
        1:       cap = '0;
        2:       cap = 5'd1;
        3:       cap = '1;
        4:       cap = CapW'(Ways + 1);
        5:       cap = CapW'($urandom_range(2, Ways - 1));
        default: cap = CapW'($urandom_range(0, 31));
      endcase
      set_capacity(cap);
      unique case (seg * 3 / NumSegs)
        0: begin
          src_idle_pct  = 13;
          sink_idle_pct = 62;
        end
        1: begin
          src_idle_pct  = 62;
          sink_idle_pct = 13;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      // a small key pool keeps hits and evictions frequent
      pool_n = $urandom_range(2, PoolMax);
      for (int i = 0; i < PoolMax; i++) key_pool[i] = $urandom();
      for (int n = 0; n < SegItems; n++) begin
        if (n == SegItems / 2 || $urandom_range(0, 99) == 0) drain_results();
        act = $urandom_range(0, 1);
        if ($urandom_range(0, 9) == 0) k = $urandom();
        else k = key_pool[$urandom_range(0, pool_n - 1)];
        send_item(act, k, $urandom(), 1'b0, '0);
      end
    end

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    $display("Run: %0d get/put items, %0d results checked, %0d of them hits",
             items_sent, checked, hits_seen);
    $display("Capacity written %0d times, from 0 and 1 up to 31, with and without stalls",
             cap_writes);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutCycles * ClkPeriod);
    $display("Timeout with %0d results outstanding", expected_resp.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
